// ===== sv/tsf_pkg.sv =====
// Shared constants and types for the triangle sine feature block.
package tsf_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W = $clog2(MAX_POINTS);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// magnitude bits of a unit vector component, one search stage per bit
	localparam int UNIT_W = 15;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	// -10 in Q5.11
	localparam logic signed [15:0] SENTINEL = -16'sd20480;

	typedef struct packed {
		logic deg;
		logic signed [15:0] x0;
		logic signed [15:0] y0;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
	} tri_t;

	typedef struct packed {
		logic deg;
		logic [2:0] neg_x;
		logic [2:0] neg_y;
		logic [2:0] zero;
	} side_t;

endpackage

// ===== sv/triangle_sine_features_top.sv =====
// Top level of the triangle sine feature engine.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------------------------
//  request | req_valid | req_stall | command, point_index, point_x/y, three indices
//  result  | res_valid | res_stall | feature_first/second/third, degenerate
//
// One word per cycle is taken while req_stall is low; write words give no result.
// A compute word's result passes the store read, the queue, the 15-stage
// normalization search and the arithmetic stages, then the result register.
// Reset (arst_n low) empties the queue and pipeline; point store is not cleared.
// res_stall freezes the back pipeline; the queue then fills and raises req_stall.
module triangle_sine_features_top import tsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic command,
	input  logic [7:0] point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [7:0] first_index,
	input  logic [7:0] second_index,
	input  logic [7:0] third_index,
	output logic res_valid,
	input  logic res_stall,
	output logic signed [15:0] feature_first,
	output logic signed [15:0] feature_second,
	output logic signed [15:0] feature_third,
	output logic degenerate
);

	logic accept;
	logic push;
	logic pop;
	tri_t front_item;
	tri_t back_item;
	logic [CNT_W-1:0] count;

	// reserve room for the word still in the front register
	assign req_stall = (CNT_W'(count) + CNT_W'(push)) >= CNT_W'(FIFO_DEPTH);
	assign accept = req_valid && !req_stall;

	tsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(command),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.first_index(first_index),
		.second_index(second_index),
		.third_index(third_index),
		.push(push),
		.item(front_item)
	);

	tsf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(front_item),
		.pop(pop),
		.rd_data(back_item),
		.count(count)
	);

	tsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(count != '0),
		.item(back_item),
		.pop(pop),
		.valid(res_valid),
		.stall(res_stall),
		.feature_first(feature_first),
		.feature_second(feature_second),
		.feature_third(feature_third),
		.degenerate(degenerate)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count == CNT_W'(FIFO_DEPTH)) |-> pop)
		else $error("queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(FIFO_DEPTH))
		else $error("queue count out of range");

	a_degenerate_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && degenerate) |->
		(feature_first == SENTINEL && feature_second == SENTINEL &&
		feature_third == SENTINEL))
		else $error("degenerate result without sentinel");

	a_feature_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !degenerate) |->
		(feature_first <= 16'sd2048 && feature_first >= -16'sd2048 &&
		feature_second <= 16'sd2048 && feature_second >= -16'sd2048 &&
		feature_third <= 16'sd2048 && feature_third >= -16'sd2048))
		else $error("feature outside unit cross range");

endmodule

// ===== sv/tsf_front.sv =====
// Front end: point store, corner reads and degenerate check.
module tsf_front import tsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic command,
	input  logic [7:0] point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [7:0] first_index,
	input  logic [7:0] second_index,
	input  logic [7:0] third_index,
	output logic push,
	output tri_t item
);

	// one copy per read port, all written together
	logic [31:0] store_q [3][MAX_POINTS];
	logic [31:0] rd_s1 [3];
	logic deg_s1;
	logic push_s1;

	always_ff @(posedge clk) begin
		if (accept && command == CMD_WRITE) begin
			for (int c = 0; c < 3; c++) begin
				store_q[c][point_index[IDX_W-1:0]] <= {point_x, point_y};
			end
		end
		if (accept && command == CMD_COMPUTE) begin
			rd_s1[0] <= store_q[0][first_index[IDX_W-1:0]];
			rd_s1[1] <= store_q[1][second_index[IDX_W-1:0]];
			rd_s1[2] <= store_q[2][third_index[IDX_W-1:0]];
			deg_s1 <= (first_index == second_index) || (first_index == third_index) ||
				(second_index == third_index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= accept && command == CMD_COMPUTE;
		end
	end

	assign push = push_s1;
	assign item.deg = deg_s1;
	assign item.x0 = rd_s1[0][31:16];
	assign item.y0 = rd_s1[0][15:0];
	assign item.x1 = rd_s1[1][31:16];
	assign item.y1 = rd_s1[1][15:0];
	assign item.x2 = rd_s1[2][31:16];
	assign item.y2 = rd_s1[2][15:0];

endmodule

// ===== sv/tsf_fifo.sv =====
// Short queue of triangle words between front and back.
module tsf_fifo import tsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tri_t wr_data,
	input  logic pop,
	output tri_t rd_data,
	output logic [CNT_W-1:0] count
);

	tri_t buf_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign rd_data = buf_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== sv/tsf_search.sv =====
// Pipelined bit search: largest m with m*m*n2 <= rem0, one bit per stage.
module tsf_search import tsf_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic [32:0] n2,
	input  logic [63:0] rem0,
	output logic [UNIT_W-1:0] m
);

	logic [32:0] n2_s [UNIT_W];
	logic [63:0] rem_s [UNIT_W];
	logic [47:0] prod_s [UNIT_W];
	logic [UNIT_W-1:0] m_s [UNIT_W];

	for (genvar j = 0; j < UNIT_W; j++) begin : g_stage
		localparam int K = UNIT_W - 1 - j;
		logic [32:0] n2_in;
		logic [63:0] rem_in;
		logic [47:0] prod_in;
		logic [UNIT_W-1:0] m_in;
		logic [64:0] dec;
		logic take;

		if (j == 0) begin : g_first
			assign n2_in = n2;
			assign rem_in = rem0;
			assign prod_in = '0;
			assign m_in = '0;
		end else begin : g_next
			assign n2_in = n2_s[j-1];
			assign rem_in = rem_s[j-1];
			assign prod_in = prod_s[j-1];
			assign m_in = m_s[j-1];
		end

		// (m + 2^K)^2 - m^2 = m*2^(K+1) + 2^(2K); prod tracks n2*m
		assign dec = (65'(prod_in) << (K + 1)) + (65'(n2_in) << (2 * K));
		assign take = dec <= 65'(rem_in);

		always_ff @(posedge clk) begin
			if (en) begin
				n2_s[j] <= n2_in;
				rem_s[j] <= take ? rem_in - dec[63:0] : rem_in;
				prod_s[j] <= take ? prod_in + (48'(n2_in) << K) : prod_in;
				m_s[j] <= take ? (m_in | (UNIT_W'(1) << K)) : m_in;
			end
		end
	end

	assign m = m_s[UNIT_W-1];

endmodule

// ===== sv/tsf_back.sv =====
// Back end: edge vectors, normalization, cross products, result register.
module tsf_back import tsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  tri_t item,
	output logic pop,
	output logic valid,
	input  logic stall,
	output logic signed [15:0] feature_first,
	output logic signed [15:0] feature_second,
	output logic signed [15:0] feature_third,
	output logic degenerate
);

	logic adv;
	logic signed [15:0] px [3];
	logic signed [15:0] py [3];
	logic signed [16:0] dx [3];
	logic signed [16:0] dy [3];

	logic v_s1, v_s2, v_s3, v_s5, v_s6;
	logic [UNIT_W-1:0] v_s4;
	side_t side_s1, side_s2, side_s3, side_s5, side_s6;
	side_t side_s4 [UNIT_W];
	logic [15:0] magx_s1 [3];
	logic [15:0] magy_s1 [3];
	logic [31:0] sqx_s2 [3];
	logic [31:0] sqy_s2 [3];
	logic [32:0] n2_s3 [3];
	logic [63:0] remx_s3 [3];
	logic [63:0] remy_s3 [3];
	logic [UNIT_W-1:0] mx [3];
	logic [UNIT_W-1:0] my [3];
	logic signed [15:0] ux_s5 [3];
	logic signed [15:0] uy_s5 [3];
	logic signed [31:0] pa_s6 [3];
	logic signed [31:0] pb_s6 [3];
	logic signed [32:0] xprod [3];
	logic signed [15:0] feat [3];

	assign adv = !(valid && stall);
	assign pop = adv && avail;

	assign px[0] = item.x0;
	assign py[0] = item.y0;
	assign px[1] = item.x1;
	assign py[1] = item.y1;
	assign px[2] = item.x2;
	assign py[2] = item.y2;

	// edge f runs from corner f to corner f+1
	always_comb begin
		for (int f = 0; f < 3; f++) begin
			dx[f] = 17'(px[(f + 1) % 3]) - 17'(px[f]);
			dy[f] = 17'(py[(f + 1) % 3]) - 17'(py[f]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= '0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= {v_s4[UNIT_W-2:0], v_s3};
			v_s5 <= v_s4[UNIT_W-1];
			v_s6 <= v_s5;
			valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.deg <= item.deg;
			for (int f = 0; f < 3; f++) begin
				magx_s1[f] <= dx[f][16] ? 16'(-dx[f]) : dx[f][15:0];
				magy_s1[f] <= dy[f][16] ? 16'(-dy[f]) : dy[f][15:0];
				side_s1.neg_x[f] <= dx[f][16];
				side_s1.neg_y[f] <= dy[f][16];
				side_s1.zero[f] <= (dx[f] == '0) && (dy[f] == '0);
			end

			side_s2 <= side_s1;
			for (int f = 0; f < 3; f++) begin
				sqx_s2[f] <= magx_s1[f] * magx_s1[f];
				sqy_s2[f] <= magy_s1[f] * magy_s1[f];
			end

			side_s3 <= side_s2;
			for (int f = 0; f < 3; f++) begin
				n2_s3[f] <= {1'b0, sqx_s2[f]} + {1'b0, sqy_s2[f]};
				remx_s3[f] <= {2'b00, sqx_s2[f], 30'd0};
				remy_s3[f] <= {2'b00, sqy_s2[f], 30'd0};
			end

			side_s4[0] <= side_s3;
			for (int j = 1; j < UNIT_W; j++) begin
				side_s4[j] <= side_s4[j-1];
			end

			side_s5 <= side_s4[UNIT_W-1];
			for (int f = 0; f < 3; f++) begin
				if (side_s4[UNIT_W-1].zero[f]) begin
					ux_s5[f] <= '0;
					uy_s5[f] <= '0;
				end else begin
					ux_s5[f] <= side_s4[UNIT_W-1].neg_x[f] ? -$signed({1'b0, mx[f]}) :
						$signed({1'b0, mx[f]});
					uy_s5[f] <= side_s4[UNIT_W-1].neg_y[f] ? -$signed({1'b0, my[f]}) :
						$signed({1'b0, my[f]});
				end
			end

			side_s6 <= side_s5;
			for (int f = 0; f < 3; f++) begin
				pa_s6[f] <= ux_s5[(f + 1) % 3] * uy_s5[f];
				pb_s6[f] <= uy_s5[(f + 1) % 3] * ux_s5[f];
			end

			degenerate <= side_s6.deg;
			feature_first <= side_s6.deg ? SENTINEL : feat[0];
			feature_second <= side_s6.deg ? SENTINEL : feat[1];
			feature_third <= side_s6.deg ? SENTINEL : feat[2];
		end
	end

	for (genvar f = 0; f < 3; f++) begin : g_edge
		tsf_search u_sx (
			.clk(clk),
			.en(adv),
			.n2(n2_s3[f]),
			.rem0(remx_s3[f]),
			.m(mx[f])
		);
		tsf_search u_sy (
			.clk(clk),
			.en(adv),
			.n2(n2_s3[f]),
			.rem0(remy_s3[f]),
			.m(my[f])
		);
		// Q2.30 down to Q5.11, floor
		assign xprod[f] = 33'(pa_s6[f]) - 33'(pb_s6[f]);
		assign feat[f] = 16'(xprod[f] >>> 19);
	end

endmodule

// ===== tb/triangle_sine_features_checker.sv =====
// Checker for the triangle sine feature block: shadow point store, feature predictor, compare.
module triangle_sine_features_checker import tsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  logic command,
	input  logic [7:0] point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [7:0] first_index,
	input  logic [7:0] second_index,
	input  logic [7:0] third_index,
	input  logic res_valid,
	input  logic res_stall,
	input  logic signed [15:0] feature_first,
	input  logic signed [15:0] feature_second,
	input  logic signed [15:0] feature_third,
	input  logic degenerate,
	output int fails,
	output int pending,
	output int results_seen
);

	typedef struct packed {
		logic signed [15:0] f0;
		logic signed [15:0] f1;
		logic signed [15:0] f2;
		logic deg;
	} sines_t;

	logic signed [15:0] shadow_x [MAX_POINTS];
	logic signed [15:0] shadow_y [MAX_POINTS];
	sines_t sines_q[$];

	// floor(|c| * 2^15 / sqrt(n2)), saturated, signed like c
	function automatic logic signed [15:0] unit_part(int c, longint unsigned n2);
		longint unsigned mag, target, lo, hi, mid;
		mag = (c < 0) ? -c : c;
		target = (mag * mag) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * n2 <= target)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (lo > 32767)
			lo = 32767;
		return (c < 0) ? -$signed(lo[15:0]) : $signed(lo[15:0]);
	endfunction

	function automatic sines_t triangle_sines(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		sines_t r;
		logic [7:0] corner [3];
		int ux [3];
		int uy [3];
		int dx, dy, nx;
		longint unsigned n2;
		longint xp;
		logic signed [15:0] feat [3];
		corner[0] = a;
		corner[1] = b;
		corner[2] = c;
		if (a == b || a == c || b == c) begin
			r.f0 = SENTINEL;
			r.f1 = SENTINEL;
			r.f2 = SENTINEL;
			r.deg = 1'b1;
			return r;
		end
		for (int f = 0; f < 3; f++) begin
			dx = int'(shadow_x[corner[(f + 1) % 3]]) - int'(shadow_x[corner[f]]);
			dy = int'(shadow_y[corner[(f + 1) % 3]]) - int'(shadow_y[corner[f]]);
			n2 = longint'(dx) * dx + longint'(dy) * dy;
			if (n2 == 0) begin
				ux[f] = 0;
				uy[f] = 0;
			end else begin
				ux[f] = unit_part(dx, n2);
				uy[f] = unit_part(dy, n2);
			end
		end
		for (int f = 0; f < 3; f++) begin
			nx = (f + 1) % 3;
			xp = longint'(ux[nx]) * uy[f] - longint'(uy[nx]) * ux[f];
			xp = xp >>> 19;
			feat[f] = xp[15:0];
		end
		r.f0 = feat[0];
		r.f1 = feat[1];
		r.f2 = feat[2];
		r.deg = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sines_t want;
		if (!arst_n) begin
			sines_q.delete();
			fails <= 0;
			results_seen <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				if (command == CMD_WRITE) begin
					shadow_x[point_index] = point_x;
					shadow_y[point_index] = point_y;
				end else begin
					sines_q.push_back(triangle_sines(first_index, second_index, third_index));
				end
			end
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (sines_q.size() == 0) begin
					$display("%0t: unexpected result word, got %0d %0d %0d deg %0b", $time,
						feature_first, feature_second, feature_third, degenerate);
					fails <= fails + 1;
				end else begin
					want = sines_q.pop_front();
					if (want.f0 !== feature_first || want.f1 !== feature_second ||
							want.f2 !== feature_third || want.deg !== degenerate) begin
						$display("%0t: mismatch, expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
							$time, want.f0, want.f1, want.f2, want.deg,
							feature_first, feature_second, feature_third, degenerate);
						fails <= fails + 1;
					end
				end
			end
		end
		pending = sines_q.size();
	end

endmodule

// ===== tb/triangle_sine_features_top_tb.sv =====
// Testbench top: clock, reset, request and stall stimulus, final verdict.
module triangle_sine_features_top_tb;
	import tsf_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid, req_stall, command;
	logic [7:0] point_index, first_index, second_index, third_index;
	logic signed [15:0] point_x, point_y;
	logic res_valid, res_stall, degenerate;
	logic signed [15:0] feature_first, feature_second, feature_third;
	int fails, pending, results_seen;
	int words_sent;
	bit calm;

	bit slot_used [MAX_POINTS];
	int used_q[$];

	always #2 clk = ~clk;

	triangle_sine_features_top DUT (.*);

	triangle_sine_features_checker checker_i (.*);

	initial begin
		#2000000;
		$display("triangle_sine_features_top_tb NOT OK");
		$finish;
	end

	// random receiver stalls in bursts
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(logic cmd, logic [7:0] pi, logic signed [15:0] px,
			logic signed [15:0] py, logic [7:0] a, logic [7:0] b, logic [7:0] c);
		command <= cmd;
		point_index <= pi;
		point_x <= px;
		point_y <= py;
		first_index <= a;
		second_index <= b;
		third_index <= c;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		words_sent++;
		if (cmd == CMD_WRITE && !slot_used[pi]) begin
			slot_used[pi] = 1'b1;
			used_q.push_back(int'(pi));
		end
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic put_point(logic [7:0] pi, logic signed [15:0] px, logic signed [15:0] py);
		send_word(CMD_WRITE, pi, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic ask(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		send_word(CMD_COMPUTE, 8'($urandom), 16'($urandom), 16'($urandom), a, b, c);
	endtask

	function automatic logic [7:0] any_used();
		return 8'(used_q[$urandom_range(0, used_q.size() - 1)]);
	endfunction

	initial begin
		logic [7:0] a, b, c;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		command <= CMD_WRITE;
		point_index <= '0;
		point_x <= '0;
		point_y <= '0;
		first_index <= '0;
		second_index <= '0;
		third_index <= '0;
		words_sent = 0;
		calm = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, a repeated point (zero-length edge), a collinear triple
		put_point(8'd0, -16'sd32768, -16'sd32768);
		put_point(8'd255, 16'sd32767, 16'sd32767);
		put_point(8'd1, 16'sd32767, -16'sd32768);
		put_point(8'd128, 16'sd0, 16'sd0);
		put_point(8'd2, 16'sd0, 16'sd0);
		put_point(8'd3, 16'sd5, 16'sd5);
		put_point(8'd4, -16'sd32768, 16'sd32767);
		ask(8'd0, 8'd255, 8'd1);
		ask(8'd1, 8'd255, 8'd0);
		ask(8'd0, 8'd1, 8'd4);
		ask(8'd128, 8'd2, 8'd3);
		ask(8'd0, 8'd128, 8'd255);
		ask(8'd3, 8'd3, 8'd0);
		ask(8'd3, 8'd0, 8'd3);
		ask(8'd0, 8'd3, 8'd3);
		ask(8'd255, 8'd255, 8'd255);

		// let everything drain before going on
		req_valid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		for (int n = 0; n < 1000; n++) begin
			if (n == 850)
				calm = 1'b1;
			if (used_q.size() < 3 || $urandom_range(0, 9) < 3) begin
				put_point(8'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				a = any_used();
				b = any_used();
				c = any_used();
				if ($urandom_range(0, 9) == 0)
					c = a;
				ask(a, b, c);
			end
		end
		req_valid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("covered %0d request words, %0d result words, %0d store slots written",
			words_sent, results_seen, used_q.size());
		if (fails == 0 && pending == 0)
			$display("triangle_sine_features_top_tb OK");
		else
			$display("triangle_sine_features_top_tb NOT OK");
		$finish;
	end

endmodule
